@@ hw/rtl/nmea_rmc_position_parser_unit_assert.svh @@
// Assertion macros shared by the RMC position parser modules.
`ifndef NMEA_RMC_POSITION_PARSER_UNIT_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_UNIT_ASSERT_SVH

// Check a condition at every rising edge outside reset.
`define NRP_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define NRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/nrp_pkg.sv @@
// Types and constants of the RMC position parser.
package nrp_pkg;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NON_DIGIT = 2'd3
   } status_type;

   typedef struct packed {
      status_type         status;
      logic signed [19:0] latitude_arcsec;
      logic signed [22:0] longitude_arcsec;
   } rsp_item_type;

   localparam logic [2:0] HEADER_LEN     = 3'd7;
   localparam logic [2:0] COMMA_LAT_OPEN = 3'd2;
   localparam logic [2:0] COMMA_LON_OPEN = 3'd4;
   localparam logic [2:0] COMMA_IN_LON   = 3'd5;
   localparam logic [2:0] COMMA_IN_LAT   = 3'd3;
   localparam logic [2:0] COMMA_MAX      = 3'd7;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Digit positions inside a field, counted from zero after any sign.
   localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
   localparam logic [3:0] LAT_DOT_POS    = 4'd4;
   localparam logic [3:0] LAT_LAST_POS   = 4'd8;
   localparam logic [3:0] LON_DEG_DIGITS = 4'd3;
   localparam logic [3:0] LON_DOT_POS    = 4'd5;
   localparam logic [3:0] LON_LAST_POS   = 4'd9;

   // Expected byte of the sentence header at each position.
   function automatic logic [7:0] header_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h24;  // '$'
         3'd1:    b = 8'h47;  // 'G'
         3'd2:    b = 8'h50;  // 'P'
         3'd3:    b = 8'h52;  // 'R'
         3'd4:    b = 8'h4D;  // 'M'
         3'd5:    b = 8'h43;  // 'C'
         default: b = CHAR_COMMA;
      endcase
      return b;
   endfunction

endpackage

@@ hw/rtl/nmea_rmc_position_parser_unit.sv @@
// Top level of the RMC position parser: input register, parser and result queue.
// Takes one sentence byte per transaction and may accept a byte in every cycle
// in which req_stall is low. Each accepted byte is captured in an input register
// and processed by the parser in the following cycle; the byte marked last yields
// one result transaction, stored in the result queue and presented on the result
// channel from the entry registers of that queue. Results pass through a
// two-entry queue, so bytes keep flowing while a result waits to be taken;
// req_stall rises only when the queue would have no room for another result.
// Status: 0 ok, 1 missing header or truncated field, 2 empty field, 3 non-digit;
// positions are signed whole arc-seconds and read zero unless the status is ok.
module nmea_rmc_position_parser_unit
   import nrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [19:0] rsp_latitude_arcsec,
   output logic signed [22:0] rsp_longitude_arcsec
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_char_ff;
   logic         in_last_ff;
   logic         result_push;
   rsp_item_type result_item;
   rsp_item_type head_item;
   logic         room_next;

   // Accept a transaction whenever the queue keeps room for its result.
   always_comb begin
      req_stall   = !room_next;
      in_valid_in = req_valid && !req_stall;
   end

   // Register the accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_char_ff <= req_char_byte;
         in_last_ff <= req_is_last;
      end
   end

   nrp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (in_valid_ff),
      .char_byte   (in_char_ff),
      .is_last     (in_last_ff),
      .result_push (result_push),
      .result_item (result_item)
   );

   nrp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_item (result_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head_item (head_item),
      .room_next (room_next)
   );

   // Unpack the head result onto the channel.
   always_comb begin
      rsp_status           = head_item.status;
      rsp_latitude_arcsec  = head_item.latitude_arcsec;
      rsp_longitude_arcsec = head_item.longitude_arcsec;
   end

endmodule

@@ hw/rtl/nrp_arcsec_conv.sv @@
// Conversion of a finished position field to signed whole arc-seconds.
module nrp_arcsec_conv
   import nrp_pkg::*;
(
   input  logic [9:0]  degrees,
   input  logic [6:0]  minutes,
   input  logic [13:0] fraction,
   input  logic [3:0]  last_digit,
   input  logic        negative,
   output logic [22:0] arcsec
);

   logic [14:0] frac_x3;
   logic [12:0] frac_q4;
   logic [25:0] recip_prod;
   logic [5:0]  seconds;
   logic [22:0] magnitude;

   // Seconds = floor(frac * 60 / 10000) = floor(floor(frac * 3 / 4) / 125),
   // with the division by 125 done as a multiply by ceil(2^20 / 125).
   always_comb begin
      frac_x3    = 15'(fraction * 15'd30) + 15'(last_digit * 15'd3);
      frac_q4    = frac_x3[14:2];
      recip_prod = 26'(frac_q4) * 26'd8389;
      seconds    = recip_prod[25:20];
      magnitude  = 23'(degrees) * 23'd3600 + 23'(minutes) * 23'd60 + 23'(seconds);
      arcsec     = negative ? (23'd0 - magnitude) : magnitude;
   end

endmodule

@@ hw/rtl/nrp_parse_core.sv @@
// Sentence state machine: header match, comma count and field accumulation.
`include "nmea_rmc_position_parser_unit_assert.svh"

module nrp_parse_core
   import nrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  logic [7:0]   char_byte,
   input  logic         is_last,
   output logic         result_push,
   output rsp_item_type result_item
);

   logic [2:0]         hdr_ff, hdr_in;
   logic [2:0]         comma_ff, comma_in;
   logic [3:0]         fp_ff, fp_in;
   logic               neg_ff, neg_in;
   logic [9:0]         deg_ff, deg_in;
   logic [6:0]         min_ff, min_in;
   logic [13:0]        frac_ff, frac_in;
   logic signed [19:0] lat_ff, lat_in;
   logic signed [22:0] lon_ff, lon_in;
   status_type         err_ff, err_in;

   logic [3:0]  digit;
   logic        is_digit;
   logic [3:0]  pos;
   logic        is_lon;
   logic [3:0]  deg_digits;
   logic [3:0]  dot_pos;
   logic [3:0]  last_pos;
   logic        sign_slot;
   logic [22:0] field_arcsec;

   nrp_arcsec_conv u_conv (
      .degrees    (deg_ff),
      .minutes    (min_ff),
      .fraction   (frac_ff),
      .last_digit (digit),
      .negative   (neg_ff),
      .arcsec     (field_arcsec)
   );

   // Decode the byte against the open field.
   always_comb begin
      digit      = 4'(char_byte - CHAR_ZERO);
      is_digit   = char_byte inside {[CHAR_ZERO:CHAR_NINE]};
      pos        = fp_ff - 4'd1;
      is_lon     = (comma_ff == COMMA_IN_LON);
      deg_digits = is_lon ? LON_DEG_DIGITS : LAT_DEG_DIGITS;
      dot_pos    = is_lon ? LON_DOT_POS : LAT_DOT_POS;
      last_pos   = is_lon ? LON_LAST_POS : LAT_LAST_POS;
      sign_slot  = (pos == 4'd0) && !neg_ff;
   end

   // Advance the sentence state and form the result on the last byte.
   always_comb begin
      hdr_in   = hdr_ff;
      comma_in = comma_ff;
      fp_in    = fp_ff;
      neg_in   = neg_ff;
      deg_in   = deg_ff;
      min_in   = min_ff;
      frac_in  = frac_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      err_in   = err_ff;

      if (item_valid && (err_ff == STATUS_OK)) begin
         if (hdr_ff < HEADER_LEN) begin
            if (char_byte == header_byte(hdr_ff)) begin
               hdr_in = hdr_ff + 3'd1;
               if (char_byte == CHAR_COMMA) begin
                  comma_in = 3'd1;
               end
            end else begin
               err_in = STATUS_SHORT;
            end
         end else if (fp_ff != 4'd0) begin
            if (sign_slot && (char_byte == CHAR_COMMA)) begin
               err_in = STATUS_EMPTY;
            end else if (sign_slot && (char_byte == CHAR_MINUS)) begin
               neg_in = 1'b1;
            end else if ((pos != dot_pos) && !is_digit) begin
               err_in = STATUS_NON_DIGIT;
            end else begin
               if (pos != dot_pos) begin
                  if (pos < deg_digits) begin
                     deg_in = 10'(deg_ff * 10'd10 + 10'(digit));
                  end else if (pos < dot_pos) begin
                     min_in = 7'(min_ff * 7'd10 + 7'(digit));
                  end else begin
                     frac_in = 14'(frac_ff * 14'd10 + 14'(digit));
                  end
               end
               // Close the field on its last fraction digit.
               if (pos >= last_pos) begin
                  if (is_lon) begin
                     lon_in = field_arcsec;
                  end else begin
                     lat_in = field_arcsec[19:0];
                  end
                  fp_in = 4'd0;
               end else begin
                  fp_in = fp_ff + 4'd1;
               end
            end
         end else if (char_byte == CHAR_COMMA) begin
            if ((comma_ff == COMMA_LAT_OPEN) || (comma_ff == COMMA_LON_OPEN)) begin
               fp_in   = 4'd1;
               neg_in  = 1'b0;
               deg_in  = 10'd0;
               min_in  = 7'd0;
               frac_in = 14'd0;
            end
            if (comma_ff < COMMA_MAX) begin
               comma_in = comma_ff + 3'd1;
            end
         end
      end

      // First error wins; otherwise an unfinished header or field is short.
      if (err_in != STATUS_OK) begin
         result_item.status = err_in;
      end else if ((hdr_in < HEADER_LEN) || (fp_in != 4'd0)) begin
         result_item.status = STATUS_SHORT;
      end else begin
         result_item.status = STATUS_OK;
      end
      result_item.latitude_arcsec  = (result_item.status == STATUS_OK) ? lat_in : 20'sd0;
      result_item.longitude_arcsec = (result_item.status == STATUS_OK) ? lon_in : 23'sd0;

      result_push = item_valid && is_last;

      // Drop all sentence state after the last byte.
      if (result_push) begin
         hdr_in   = 3'd0;
         comma_in = 3'd0;
         fp_in    = 4'd0;
         neg_in   = 1'b0;
         deg_in   = 10'd0;
         min_in   = 7'd0;
         frac_in  = 14'd0;
         lat_in   = 20'sd0;
         lon_in   = 23'sd0;
         err_in   = STATUS_OK;
      end
   end

   // Hold the sentence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= 3'd0;
         comma_ff <= 3'd0;
         fp_ff    <= 4'd0;
         neg_ff   <= 1'b0;
         deg_ff   <= 10'd0;
         min_ff   <= 7'd0;
         frac_ff  <= 14'd0;
         lat_ff   <= 20'sd0;
         lon_ff   <= 23'sd0;
         err_ff   <= STATUS_OK;
      end else begin
         hdr_ff   <= hdr_in;
         comma_ff <= comma_in;
         fp_ff    <= fp_in;
         neg_ff   <= neg_in;
         deg_ff   <= deg_in;
         min_ff   <= min_in;
         frac_ff  <= frac_in;
         lat_ff   <= lat_in;
         lon_ff   <= lon_in;
         err_ff   <= err_in;
      end
   end

   `NRP_ASSERT_HOLDS(a_field_after_header, (fp_ff == 4'd0) || (hdr_ff == HEADER_LEN), "field open before header complete")
   `NRP_ASSERT_HOLDS(a_field_comma, (fp_ff == 4'd0) || (comma_ff == COMMA_IN_LAT) || (comma_ff == COMMA_IN_LON), "field open at wrong comma")
   `NRP_ASSERT_NEXT(a_clear_after_last, item_valid && is_last, (hdr_ff == 3'd0) && (fp_ff == 4'd0) && (err_ff == STATUS_OK), "state not cleared after last byte")

endmodule

@@ hw/rtl/nrp_result_queue.sv @@
// Two-entry result queue that parts the parser from the result channel.
`include "nmea_rmc_position_parser_unit_assert.svh"

module nrp_result_queue
   import nrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_item_type head_item,
   output logic         room_next
);

   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   rsp_item_type entry_ff [2];
   logic         pop;

   // Track occupancy; room_next says a further result fits after this cycle.
   always_comb begin
      rsp_valid = (count_ff != 2'd0);
      pop       = rsp_valid && !rsp_stall;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      room_next = (count_in != 2'd2);
      head_item = entry_ff[rd_ptr_ff];
   end

   // Hold pointers and count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store a pushed result.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `NRP_ASSERT_HOLDS(a_count_bound, count_ff != 2'd3, "result queue count out of range")
   `NRP_ASSERT_HOLDS(a_no_overflow, !(push && (count_ff == 2'd2) && !pop), "result pushed into full queue")
   `NRP_ASSERT_HOLDS(a_full_ptrs, (count_ff != 2'd2) || (wr_ptr_ff == rd_ptr_ff), "pointers disagree with full count")

endmodule
